[src/sliding_window_rate_limiter_assert.svh]
// Assertion macros for the rate limiter. Empty when SYNTHESIS is set.
`ifndef SLIDING_WINDOW_RATE_LIMITER_ASSERT_SVH
`define SLIDING_WINDOW_RATE_LIMITER_ASSERT_SVH

`ifndef SYNTHESIS
// Checked only out of reset.
`define SWRL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked in every cycle, reset included.
`define SWRL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SWRL_ASSERT(lbl, prop, msg)
`define SWRL_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

[src/swrl_pkg.sv]
package swrl_pkg;

  localparam int unsigned NOW_MS_W   = 48;
  localparam int unsigned MAX_EV_W   = 7;
  localparam int unsigned WINDOW_W   = 32;
  localparam int unsigned HELD_W     = 7;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 32;

  localparam int unsigned RING_DEPTH_DEF = 64;
  localparam int unsigned STAMP_BITS_DEF = 48;

  localparam logic [MAX_EV_W-1:0] EV_LIMIT_RST = 7'd16;
  localparam logic [WINDOW_W-1:0] WIN_LEN_RST  = 32'd1000;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_EV_LIMIT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIN_LEN  = 1'd1;

  // Input action codes.
  localparam logic ACT_REQUEST = 1'b0;
  localparam logic ACT_CLEAR   = 1'b1;

  // Per-cycle command to every cell of the chain.
  typedef struct packed {
    logic shift;  // advance every stamp one cell toward the head
    logic push;   // write the new stamp into the tail cell
  } swrl_cell_ctrl_t;

endpackage

[src/swrl_in_if.sv]
interface swrl_in_if import swrl_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                action;
  logic [NOW_MS_W-1:0] now_ms;

  modport source (output valid, output action, output now_ms, input ready);
  modport sink   (input valid, input action, input now_ms, output ready);
endinterface

[src/swrl_out_if.sv]
interface swrl_out_if import swrl_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              granted;
  logic [HELD_W-1:0] held_count;

  modport source (output valid, output granted, output held_count, input ready);
  modport sink   (input valid, input granted, input held_count, output ready);
endinterface

[src/swrl_cfg_if.sv]
interface swrl_cfg_if import swrl_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[src/swrl_cell.sv]
module swrl_cell import swrl_pkg::*; #(
  parameter int unsigned STAMP_W = STAMP_BITS_DEF
) (
  input  logic               clk,
  input  swrl_cell_ctrl_t    ctrl,
  input  logic               tail_hit,
  input  logic [STAMP_W-1:0] next_stamp,
  input  logic [STAMP_W-1:0] push_stamp,
  output logic [STAMP_W-1:0] stamp
);

  logic [STAMP_W-1:0] stamp_r;
  logic [STAMP_W-1:0] stamp_nxt;

  always_comb begin
    stamp_nxt = stamp_r;
    if (ctrl.shift) begin
      stamp_nxt = next_stamp;
    end else if (ctrl.push && tail_hit) begin
      stamp_nxt = push_stamp;
    end
  end

  always_ff @(posedge clk) begin
    stamp_r <= stamp_nxt;
  end

  assign stamp = stamp_r;

endmodule

[src/swrl_cell_row.sv]
module swrl_cell_row import swrl_pkg::*; #(
  parameter int unsigned DEPTH   = RING_DEPTH_DEF,
  parameter int unsigned STAMP_W = STAMP_BITS_DEF,
  parameter int unsigned CNT_W   = $clog2(RING_DEPTH_DEF + 1)
) (
  input  logic               clk,
  input  swrl_cell_ctrl_t    ctrl,
  input  logic [CNT_W-1:0]   count,
  input  logic [STAMP_W-1:0] push_stamp,
  output logic [STAMP_W-1:0] head_stamp
);

  logic [STAMP_W-1:0] stamp [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [STAMP_W-1:0] next_stamp;
    logic               tail_hit;

    // The last cell has no neighbor; what it shifts in is never read.
    if (i == DEPTH - 1) begin : g_last
      assign next_stamp = stamp[i];
    end else begin : g_mid
      assign next_stamp = stamp[i+1];
    end

    assign tail_hit = (count == CNT_W'(i));

    swrl_cell #(
      .STAMP_W (STAMP_W)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .tail_hit   (tail_hit),
      .next_stamp (next_stamp),
      .push_stamp (push_stamp),
      .stamp      (stamp[i])
    );
  end

  assign head_stamp = stamp[0];

endmodule

[src/sliding_window_rate_limiter.sv]
// Sliding-window event rate limiter.
// in_ch  : one item per request or clear: action (0 request, 1 clear) and
//          now_ms, a non-decreasing millisecond timestamp.
// out_ch : exactly one item per input item: granted and held_count, the
//          number of timestamps stored after the step.
// cfg_ch : register writes, index 0 the event limit, index 1 the window
//          length in ms; always ready. Write only while no item is in flight.
// Storage is a chain of RING_DEPTH cells; cell 0 holds the oldest stamp.
// An expired head is dropped by shifting the whole chain one cell toward
// the head; a grant writes now_ms into the cell addressed by the count.
// A clear goes straight to its result; a request first drops expired
// stamps, one per cycle at the head cell, then is granted or denied.
// Since each grant stores at most one stamp, the drops average at most one per
// request. The result appears in out_ch the cycle after the decision.
// The output register frees in_ch: a new item is accepted while the last
// result still waits. If the receiver stalls, the next decision holds until
// the output register is free; nothing is dropped.
// Reset empties the chain and restores an event limit of 16 and a 1000 ms window.
module sliding_window_rate_limiter import swrl_pkg::*; #(
  parameter int unsigned RING_DEPTH = RING_DEPTH_DEF,
  parameter int unsigned STAMP_BITS = STAMP_BITS_DEF
) (
  input logic        clk,
  input logic        rst_n,
  swrl_in_if.sink    in_ch,
  swrl_out_if.source out_ch,
  swrl_cfg_if.sink   cfg_ch
);

  localparam int unsigned CNT_W  = $clog2(RING_DEPTH + 1);
  localparam int unsigned KEEP_W = (STAMP_BITS < NOW_MS_W) ? STAMP_BITS : NOW_MS_W;
  localparam int unsigned CMP_W  = (STAMP_BITS > WINDOW_W) ? STAMP_BITS : WINDOW_W;
  localparam int unsigned LIM_W  = (CNT_W > MAX_EV_W) ? CNT_W : MAX_EV_W;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

  // Configuration registers.
  logic [MAX_EV_W-1:0] ev_limit_r;
  logic [WINDOW_W-1:0] window_r;

  // Control state.
  state_t          state_r,     state_nxt;
  logic [CNT_W-1:0] count_r,    count_nxt;
  logic            out_valid_r, out_valid_nxt;

  // Item under work and the result register.
  logic                  clear_r,   clear_nxt;
  logic                  expire_r,  expire_nxt;
  logic [STAMP_BITS-1:0] now_r,     now_nxt;
  logic [CMP_W-1:0]      cutoff_r,  cutoff_nxt;
  logic                  granted_r, granted_nxt;
  logic [HELD_W-1:0]     held_r,    held_nxt;

  logic                  in_fire;
  logic [STAMP_BITS-1:0] stamp_in;
  logic [CMP_W-1:0]      now_cmp;
  logic [CMP_W-1:0]      win_cmp;
  logic [STAMP_BITS-1:0] head_stamp;
  logic                  head_old;
  logic                  out_free;
  logic [LIM_W-1:0]      limit;
  logic [LIM_W-1:0]      count_ext;
  swrl_cell_ctrl_t       ctrl;

  // Configuration writes: one-bit index, so every write lands.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ev_limit_r <= EV_LIMIT_RST;
      window_r   <= WIN_LEN_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_EV_LIMIT: ev_limit_r <= cfg_ch.data[MAX_EV_W-1:0];
        CFG_WIN_LEN:  window_r   <= cfg_ch.data[WINDOW_W-1:0];
      endcase
    end
  end

  // Accept only between items; the output register decouples the receiver.
  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;

  // Keep STAMP_BITS of the timestamp, then form the cutoff at accept time.
  assign stamp_in = STAMP_BITS'(in_ch.now_ms[KEEP_W-1:0]);
  assign now_cmp  = CMP_W'(stamp_in);
  assign win_cmp  = CMP_W'(window_r);

  // A limit above the chain length acts as the chain length.
  assign count_ext = LIM_W'(count_r);
  assign limit     = (LIM_W'(ev_limit_r) > LIM_W'(RING_DEPTH)) ? LIM_W'(RING_DEPTH)
                                                                : LIM_W'(ev_limit_r);

  assign head_old = (CMP_W'(head_stamp) < cutoff_r);
  assign out_free = !out_valid_r || out_ch.ready;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    clear_nxt     = clear_r;
    expire_nxt    = expire_r;
    now_nxt       = now_r;
    cutoff_nxt    = cutoff_r;
    granted_nxt   = granted_r;
    held_nxt      = held_r;
    ctrl          = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          clear_nxt  = (in_ch.action == ACT_CLEAR);
          now_nxt    = stamp_in;
          expire_nxt = (now_cmp >= win_cmp);
          cutoff_nxt = now_cmp - win_cmp;
          state_nxt  = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!clear_r && expire_r && (count_r != '0) && head_old) begin
          // Drop the expired head: advance the whole chain.
          ctrl.shift = 1'b1;
          count_nxt  = count_r - CNT_W'(1);
        end else if (out_free) begin
          if (clear_r) begin
            count_nxt   = '0;
            granted_nxt = 1'b0;
            held_nxt    = '0;
          end else if (count_ext < limit) begin
            ctrl.push   = 1'b1;
            count_nxt   = count_r + CNT_W'(1);
            granted_nxt = 1'b1;
            held_nxt    = HELD_W'(count_ext + LIM_W'(1));
          end else begin
            granted_nxt = 1'b0;
            held_nxt    = HELD_W'(count_ext);
          end
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    clear_r   <= clear_nxt;
    expire_r  <= expire_nxt;
    now_r     <= now_nxt;
    cutoff_r  <= cutoff_nxt;
    granted_r <= granted_nxt;
    held_r    <= held_nxt;
  end

  swrl_cell_row #(
    .DEPTH   (RING_DEPTH),
    .STAMP_W (STAMP_BITS),
    .CNT_W   (CNT_W)
  ) u_row (
    .clk        (clk),
    .ctrl       (ctrl),
    .count      (count_r),
    .push_stamp (now_r),
    .head_stamp (head_stamp)
  );

  assign out_ch.valid      = out_valid_r;
  assign out_ch.granted    = granted_r;
  assign out_ch.held_count = held_r;

`include "sliding_window_rate_limiter_assert.svh"

  `SWRL_ASSERT(a_count_in_range, count_r <= CNT_W'(RING_DEPTH), "count beyond chain length")
  `SWRL_ASSERT(a_shift_drops_one, ctrl.shift |=> count_r == $past(count_r) - CNT_W'(1), "drop missed")
  `SWRL_ASSERT(a_grant_in_limit, out_valid_r && granted_r |-> held_r <= ev_limit_r, "over limit")
  `SWRL_ASSERT_ALWAYS(a_reset_empties, !rst_n |=> count_r == '0 && !out_valid_r, "reset not clean")

endmodule

[bench/tb_top.sv]
module tb_top;
  import swrl_pkg::*;

  // Stop the run well past the slowest legal pace: every request purging a
  // full ring, every result stalled, every item preceded by a long gap.
  localparam int unsigned RUN_LIMIT    = 2_000_000;
  localparam int unsigned PHASE_COUNT  = 10;
  localparam int unsigned PHASE_ITEMS  = 200;
  // Drain margin, sized for a request that drops a full ring of RING_DEPTH stamps.
  localparam int unsigned DRAIN_CYCLES = RING_DEPTH_DEF + 8;
  localparam int unsigned IDLE_GUARD   = 4;
  localparam int unsigned REPORT_MAX   = 10;

  // One decision as it leaves the block.
  typedef struct packed {
    logic              granted;
    logic [HELD_W-1:0] held_count;
  } verdict_t;

  logic clk = 1'b0;
  logic rst_n;

  swrl_in_if  req_bus ();
  swrl_out_if verdict_bus ();
  swrl_cfg_if cfg_bus ();

  sliding_window_rate_limiter u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req_bus),
    .out_ch (verdict_bus),
    .cfg_ch (cfg_bus)
  );

  // Shadow of the block: the stamps of granted events, oldest first, and
  // the two registers as last written.
  logic [NOW_MS_W-1:0] granted_stamps[$];
  logic [MAX_EV_W-1:0] event_cap;
  logic [WINDOW_W-1:0] window_len;

  // Decisions accepted on the request side and not yet seen at the output.
  verdict_t awaited[$];

  int unsigned mismatch_count = 0;
  int unsigned checked_count  = 0;
  int unsigned cycle_count    = 0;
  int unsigned tx_gap_pct     = 0;
  int unsigned rx_stall_pct   = 0;
  int unsigned rx_stall_left  = 0;
  int unsigned n_items        = 0;
  int unsigned n_granted      = 0;
  int unsigned n_denied       = 0;
  int unsigned n_clears       = 0;
  int unsigned n_settings     = 0;
  int unsigned peak_held      = 0;
  logic [NOW_MS_W-1:0] clock_ms;

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // Idle length for either side: none with a chance of 100 - pct percent, else
  // usually short and rarely a long stretch.
  function automatic int unsigned pick_delay(int unsigned pct);
    if ($urandom_range(99) >= pct) return 0;
    if ($urandom_range(9) == 0) return $urandom_range(40, 10);
    return $urandom_range(3, 1);
  endfunction

  function automatic logic [NOW_MS_W-1:0] rand_stamp();
    logic [63:0] word;
    word = {$urandom, $urandom};
    return word[NOW_MS_W-1:0];
  endfunction

  // Apply one item to the shadow state and return the decision it yields.
  function automatic verdict_t judge_item(logic act, logic [NOW_MS_W-1:0] stamp);
    verdict_t            v;
    int unsigned         cap;
    logic [NOW_MS_W-1:0] span;
    span = window_len;
    n_items++;
    if (act == ACT_CLEAR) begin
      granted_stamps.delete();
      n_clears++;
      v.granted    = 1'b0;
      v.held_count = '0;
      return v;
    end
    // Expire only once the clock has passed one full window; a stamp equal
    // to the cutoff survives.
    if (stamp >= span) begin
      while (granted_stamps.size() > 0 && granted_stamps[0] < stamp - span)
        void'(granted_stamps.pop_front());
    end
    // A limit above the ring size acts as the ring size.
    cap = (event_cap > RING_DEPTH_DEF) ? RING_DEPTH_DEF : event_cap;
    v.granted = (granted_stamps.size() < cap);
    if (v.granted) begin
      granted_stamps = {granted_stamps, stamp};
      n_granted++;
    end else begin
      n_denied++;
    end
    v.held_count = HELD_W'(granted_stamps.size());
    if (granted_stamps.size() > peak_held) peak_held = granted_stamps.size();
    return v;
  endfunction

  // Offer one item and hold it until accepted. Valid stays high when the
  // next item follows at once, so it is never dropped and raised in one step.
  task automatic send_item(logic act, logic [NOW_MS_W-1:0] stamp);
    int unsigned gap;
    req_bus.valid  <= 1'b1;
    req_bus.action <= act;
    req_bus.now_ms <= stamp;
    do @(posedge clk); while (!req_bus.ready);
    awaited = {awaited, judge_item(act, stamp)};
    gap = pick_delay(tx_gap_pct);
    if (gap > 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop valid, wait for every pending decision, then let the block go quiet.
  task automatic settle(int unsigned extra);
    req_bus.valid <= 1'b0;
    while (awaited.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    do @(posedge clk); while (!cfg_bus.ready);
    if (idx == CFG_EV_LIMIT) event_cap = value[MAX_EV_W-1:0];
    else window_len = value[WINDOW_W-1:0];
  endtask

  // Write both registers back to back with the block idle.
  task automatic set_config(logic [CFG_DATA_W-1:0] cap_word, logic [CFG_DATA_W-1:0] win_word);
    settle(IDLE_GUARD);
    write_reg(CFG_EV_LIMIT, cap_word);
    write_reg(CFG_WIN_LEN, win_word);
    cfg_bus.valid <= 1'b0;
    n_settings++;
  endtask

  // Reset values: limit 16, window 1000.
  task automatic test_defaults();
    send_item(ACT_REQUEST, 48'd0);     // clock below the window: nothing expires
    send_item(ACT_REQUEST, 48'd500);
    send_item(ACT_REQUEST, 48'd1500);  // cutoff 500: drop the stamp at zero only
    send_item(ACT_CLEAR, 48'd1500);
  endtask

  // A limit of zero denies everything, even with an empty history.
  task automatic test_zero_limit();
    set_config(32'd0, 32'd1000);
    send_item(ACT_REQUEST, 48'd10);
    send_item(ACT_REQUEST, 48'd2000);
  endtask

  // Fill to the limit, deny at the boundary, then expire and grant again.
  task automatic test_limit_and_expiry();
    set_config(32'd2, 32'd10);
    send_item(ACT_REQUEST, 48'd100);
    send_item(ACT_REQUEST, 48'd100);
    send_item(ACT_REQUEST, 48'd100);   // full: deny
    send_item(ACT_REQUEST, 48'd110);   // cutoff equals stamps: keep them
    send_item(ACT_REQUEST, 48'd111);   // cutoff past both: drop both, grant
  endtask

  // Time going backwards is compared as given and appended at the tail.
  task automatic test_time_backwards();
    send_item(ACT_REQUEST, 48'd50);
    send_item(ACT_REQUEST, 48'd200);
  endtask

  // Zero window; upper data bits of the limit word are ignored.
  task automatic test_zero_window();
    set_config(32'hFFFF_FF82, 32'd0);
    send_item(ACT_REQUEST, 48'd300);
    send_item(ACT_REQUEST, 48'd300);   // equal stamp is not below the cutoff
    send_item(ACT_REQUEST, 48'd301);
  endtask

  // Widest window, limit above ring size, top and bottom of the stamp range.
  task automatic test_extremes();
    set_config(32'h0000_007F, 32'hFFFF_FFFF);
    send_item(ACT_REQUEST, 48'hFFFF_FFFF_FFFF);
    send_item(ACT_REQUEST, 48'd0);
    send_item(ACT_CLEAR, 48'hFFFF_FFFF_FFFF);
  endtask

  // Phases of mostly rising time with random content, a few clears, wild
  // stamps and jumps that flush the whole history.
  task automatic test_random_phases();
    logic [CFG_DATA_W-1:0] cap_word;
    logic [CFG_DATA_W-1:0] win_word;
    logic [MAX_EV_W-1:0]   cap;
    int unsigned           step_max;
    int unsigned           roll;
    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      case (phase)
        0: begin
          cap      = 7'd64;               // fill the ring to its last slot
          win_word = 32'hFFFF_FFFF;
        end
        1: begin
          cap      = 7'd127;
          win_word = 32'd0;
        end
        2: begin
          cap      = 7'd0;
          win_word = $urandom_range(500, 1);
        end
        3: begin
          cap      = MAX_EV_W'($urandom_range(16, 1));
          win_word = 32'd1;
        end
        4: begin
          cap      = 7'd65;
          win_word = $urandom_range(400, 100);
        end
        default: begin
          cap = MAX_EV_W'($urandom_range(70));
          case ($urandom_range(2))
            0: win_word = $urandom_range(64);
            1: win_word = $urandom_range(3000, 64);
            default: win_word = $urandom;
          endcase
        end
      endcase
      cap_word = $urandom;
      cap_word[MAX_EV_W-1:0] = cap;
      set_config(cap_word, win_word);

      // Keep one phase free of idling on both sides.
      if (phase == 5) begin
        tx_gap_pct   = 0;
        rx_stall_pct = 0;
      end else begin
        tx_gap_pct   = 10 * $urandom_range(6);
        rx_stall_pct = 10 * $urandom_range(6);
      end

      clock_ms = (phase % 2 == 0) ? NOW_MS_W'($urandom_range(50)) : rand_stamp();
      step_max = (window_len <= 600) ? window_len / 4 + 1 : 50;

      for (int i = 0; i < PHASE_ITEMS; i++) begin
        roll = $urandom_range(99);
        if (roll < 3) begin
          send_item(ACT_CLEAR, rand_stamp());
        end else if (roll < 6) begin
          send_item(ACT_REQUEST, rand_stamp());
        end else if (roll < 8) begin
          clock_ms = clock_ms + window_len + $urandom_range(100, 1);
          send_item(ACT_REQUEST, clock_ms);
        end else begin
          clock_ms = clock_ms + $urandom_range(step_max);
          send_item(ACT_REQUEST, clock_ms);
        end
      end
    end
    tx_gap_pct   = 0;
    rx_stall_pct = 0;
  endtask

  // Check each accepted result against the oldest pending decision and
  // drive the output ready with random stalls.
  always @(posedge clk) begin
    verdict_t want;
    if (rst_n && verdict_bus.valid && verdict_bus.ready) begin
      checked_count++;
      if (awaited.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
          $display("tb: result %0d with nothing pending: granted=%0b held_count=%0d",
                   checked_count, verdict_bus.granted, verdict_bus.held_count);
      end else begin
        want = awaited.pop_front();
        if (verdict_bus.granted !== want.granted ||
            verdict_bus.held_count !== want.held_count) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX)
            $display("tb: result %0d expected granted=%0b held_count=%0d, got %0b %0d",
                     checked_count, want.granted, want.held_count,
                     verdict_bus.granted, verdict_bus.held_count);
        end
      end
    end
    if (rx_stall_left > 0) begin
      verdict_bus.ready <= 1'b0;
      rx_stall_left--;
    end else begin
      verdict_bus.ready <= 1'b1;
      rx_stall_left = pick_delay(rx_stall_pct);
    end
  end

  // Watchdog: end the run if it hangs.
  initial begin
    while (cycle_count < RUN_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: timeout after %0d cycles, %0d decisions pending", cycle_count, awaited.size());
    $display("tb: failure");
    $finish;
  end

  initial begin
    // Drive every input to a known value before the first edge; the output
    // ready comes from the checker process.
    rst_n          <= 1'b0;
    req_bus.valid  <= 1'b0;
    req_bus.action <= ACT_REQUEST;
    req_bus.now_ms <= '0;
    cfg_bus.valid  <= 1'b0;
    cfg_bus.index  <= CFG_EV_LIMIT;
    cfg_bus.data   <= '0;
    event_cap  = EV_LIMIT_RST;
    window_len = WIN_LEN_RST;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    test_defaults();
    test_zero_limit();
    test_limit_and_expiry();
    test_time_backwards();
    test_zero_window();
    test_extremes();
    test_random_phases();

    settle(DRAIN_CYCLES);
    $display("tb: %0d items (%0d granted, %0d denied, %0d clears) over %0d register settings",
             n_items, n_granted, n_denied, n_clears, n_settings);
    $display("tb: %0d results checked, peak of %0d stored stamps, %0d mismatches",
             checked_count, peak_held, mismatch_count);
    if (mismatch_count == 0 && awaited.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+src
src/swrl_pkg.sv
src/swrl_in_if.sv
src/swrl_out_if.sv
src/swrl_cfg_if.sv
src/swrl_cell.sv
src/swrl_cell_row.sv
src/sliding_window_rate_limiter.sv
bench/tb_top.sv
